/* rtl/core/brr_pkg.sv */
// shared types and codes for the bicubic row resampler
// holds command, result and configuration structs and the back-end state type
// no dependencies
package brr_pkg;

   localparam logic [1:0] MODE_SPAN   = 2'd0;
   localparam logic [1:0] MODE_WEIGHT = 2'd1;
   localparam logic [1:0] MODE_PIXEL  = 2'd2;

   localparam logic REG_IN_WIDTH  = 1'b0;
   localparam logic REG_OUT_WIDTH = 1'b1;

   localparam int RESULT_LIMIT = 32;
   localparam logic [7:0] CHAN_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_SPAN,
      KIND_WEIGHT,
      KIND_PIXEL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [9:0]         index;
      logic [3:0]         tap;
      logic [10:0]        first;
      logic [4:0]         count;
      logic signed [24:0] weight;
      logic [23:0]        pixel;
   } cmd_type;

   typedef struct packed {
      logic [11:0] in_width;
      logic [10:0] out_width;
   } cfg_type;

   typedef struct packed {
      logic [9:0] column;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_of_run;
      logic       row_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN_RD,
      ST_SPAN_CHK,
      ST_TAPS,
      ST_DRAIN,
      ST_EMIT,
      ST_FLUSH
   } back_state_type;

endpackage

/* rtl/core/brr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module brr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/brr_fifo.sv */
// small register queue used between front and back end and on the result side
// no dependencies
module brr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      if (do_push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (do_pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/brr_front.sv */
// front end: accepts input items, drops meaningless ones, queues commands
// depends on brr_pkg and brr_fifo
module brr_front import brr_pkg::*; #(
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_TAPS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_out_index,
   input  logic [3:0]         req_tap,
   input  logic [10:0]        req_first_pixel,
   input  logic [4:0]         req_tap_count,
   input  logic signed [24:0] req_weight,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic               cmd_pop,
   output cmd_type            cmd,
   output logic               cmd_empty
);

   logic    keep;
   logic    index_ok;
   cmd_type cmd_new;
   logic [$bits(cmd_type)-1:0] q_rdata;

   assign index_ok = ({22'd0, req_out_index} < 32'(MAX_OUT_WIDTH));

   always_comb begin
      cmd_new.index  = req_out_index;
      cmd_new.tap    = req_tap;
      cmd_new.first  = req_first_pixel;
      cmd_new.count  = req_tap_count;
      cmd_new.weight = req_weight;
      cmd_new.pixel  = {req_red, req_green, req_blue};
      unique case (req_mode)
         MODE_SPAN: begin
            cmd_new.kind = KIND_SPAN;
            keep         = index_ok;
         end
         MODE_WEIGHT: begin
            cmd_new.kind = KIND_WEIGHT;
            keep         = index_ok && ({28'd0, req_tap} < 32'(MAX_TAPS));
         end
         MODE_PIXEL: begin
            cmd_new.kind = KIND_PIXEL;
            keep         = 1'b1;
         end
         default: begin
            cmd_new.kind = KIND_PIXEL;
            keep         = 1'b0;
         end
      endcase
   end

   brr_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push && keep),
      .wdata (cmd_new),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (cmd_empty)
   );

   assign cmd = cmd_type'(q_rdata);

endmodule

/* rtl/core/brr_back.sv */
// back end: table loads, row store writes and the per-column multiply-accumulate walk
// depends on brr_pkg, brr_ram and brr_fifo
module brr_back import brr_pkg::*; #(
   parameter int MAX_IN_WIDTH  = 2048,
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_TAPS      = 16,
   parameter int FRACTION_BITS = 22
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   input  logic    pop,
   output rsp_type rsp,
   output logic    empty
);

   localparam int IPW    = $clog2(MAX_IN_WIDTH + 1);
   localparam int RAW    = $clog2(MAX_IN_WIDTH);
   localparam int OCW    = $clog2(MAX_OUT_WIDTH + 1);
   localparam int SAW    = $clog2(MAX_OUT_WIDTH);
   localparam int TW     = $clog2(MAX_TAPS);
   localparam int CW     = $clog2(MAX_TAPS + 1);
   localparam int WDEPTH = MAX_OUT_WIDTH << TW;
   localparam int NW     = $clog2(RESULT_LIMIT + 1);
   localparam logic [31:0] BIAS = 32'd1 << (FRACTION_BITS - 1);

   function automatic logic [7:0] clip(input logic [31:0] a);
      logic [31:0] v;
      begin
         v = a >> FRACTION_BITS;
         if (a[31]) begin
            clip = 8'd0;
         end else if (v > 32'd255) begin
            clip = CHAN_MAX;
         end else begin
            clip = v[7:0];
         end
      end
   endfunction

   back_state_type state_ff, state_in;
   logic [IPW-1:0] ptr_ff, ptr_in;
   logic [OCW-1:0] col_ff, col_in;
   logic [NW-1:0]  n_ff, n_in;
   logic           last_ff, last_in;
   logic [10:0]    first_ff, first_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [2:0][31:0] acc_ff, acc_in, prod_ff, prod_in;
   logic           v1_ff, nz1_ff, v2_ff;
   rsp_type        pend_ff, pend_in;
   logic           pend_v_ff, pend_v_in;

   logic [31:0] iw32, ow32, ptr32, col32, p32, pnext32, end32, src32, cnt_sel;
   logic        more, ready, issue, acc_start, src_ok;
   logic        row_we, span_we, w_we, rsp_push, rsp_full;
   rsp_type     rsp_data, res_new;
   logic [15:0] span_rd;
   logic [23:0] px_rd;
   logic signed [24:0] w_rd;
   logic [$bits(rsp_type)-1:0] rq_rdata;
   logic signed [33:0] mul [3];

   // effective widths, clamped into range
   always_comb begin
      if (cfg.in_width == '0) begin
         iw32 = 32'd1;
      end else if ({20'd0, cfg.in_width} > 32'(MAX_IN_WIDTH)) begin
         iw32 = 32'(MAX_IN_WIDTH);
      end else begin
         iw32 = {20'd0, cfg.in_width};
      end
      if (cfg.out_width == '0) begin
         ow32 = 32'd1;
      end else if ({21'd0, cfg.out_width} > 32'(MAX_OUT_WIDTH)) begin
         ow32 = 32'(MAX_OUT_WIDTH);
      end else begin
         ow32 = {21'd0, cfg.out_width};
      end
   end

   assign ptr32   = 32'(ptr_ff);
   assign col32   = 32'(col_ff);
   assign p32     = (ptr32 >= iw32) ? 32'd0 : ptr32;
   assign pnext32 = p32 + 32'd1;
   assign more    = (n_ff < NW'(RESULT_LIMIT)) && (col32 < ow32);
   assign cnt_sel = ({27'd0, span_rd[4:0]} > 32'(MAX_TAPS)) ? 32'(MAX_TAPS)
                                                           : {27'd0, span_rd[4:0]};
   assign end32   = {21'd0, span_rd[15:5]} + cnt_sel;
   assign ready   = last_ff || !(end32 > ptr32);
   assign src32   = {21'd0, first_ff} + 32'(i_ff);
   assign src_ok  = (src32 < 32'(MAX_IN_WIDTH));
   assign issue   = (state_ff == ST_TAPS) && (i_ff != cnt_ff);

   always_comb begin
      res_new.column      = col32[9:0];
      res_new.red         = clip(acc_ff[0]);
      res_new.green       = clip(acc_ff[1]);
      res_new.blue        = clip(acc_ff[2]);
      res_new.last_of_run = 1'b0;
      res_new.row_done    = ((col32 + 32'd1) == ow32);
   end

   brr_ram #(.WIDTH(24), .DEPTH(MAX_IN_WIDTH)) u_row_store (
      .clock (clock),
      .we    (row_we),
      .waddr (p32[RAW-1:0]),
      .wdata (cmd.pixel),
      .raddr (src32[RAW-1:0]),
      .rdata (px_rd)
   );

   brr_ram #(.WIDTH(16), .DEPTH(MAX_OUT_WIDTH)) u_span_table (
      .clock (clock),
      .we    (span_we),
      .waddr (SAW'({22'd0, cmd.index})),
      .wdata ({cmd.first, cmd.count}),
      .raddr (col_ff[SAW-1:0]),
      .rdata (span_rd)
   );

   brr_ram #(.WIDTH(25), .DEPTH(WDEPTH)) u_weight_table (
      .clock (clock),
      .we    (w_we),
      .waddr ({SAW'({22'd0, cmd.index}), TW'({28'd0, cmd.tap})}),
      .wdata (cmd.weight),
      .raddr ({col_ff[SAW-1:0], i_ff[TW-1:0]}),
      .rdata (w_rd)
   );

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && cmd.kind == KIND_PIXEL) state_in = ST_SPAN_RD;
         end
         ST_SPAN_RD:  state_in = more ? ST_SPAN_CHK : ST_FLUSH;
         ST_SPAN_CHK: state_in = ready ? ST_TAPS : ST_FLUSH;
         ST_TAPS: begin
            if (i_ff == cnt_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!pend_v_ff || !rsp_full) state_in = ST_SPAN_RD;
         end
         ST_FLUSH: begin
            if (!pend_v_ff || !rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin : outputs
      cmd_pop   = 1'b0;
      row_we    = 1'b0;
      span_we   = 1'b0;
      w_we      = 1'b0;
      ptr_in    = ptr_ff;
      col_in    = col_ff;
      n_in      = n_ff;
      last_in   = last_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      acc_start = 1'b0;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      rsp_push  = 1'b0;
      rsp_data  = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  KIND_SPAN:   span_we = 1'b1;
                  KIND_WEIGHT: w_we    = 1'b1;
                  KIND_PIXEL: begin
                     row_we  = 1'b1;
                     ptr_in  = pnext32[IPW-1:0];
                     last_in = (pnext32 >= iw32);
                     n_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SPAN_CHK: begin
            if (ready) begin
               first_in  = span_rd[15:5];
               cnt_in    = cnt_sel[CW-1:0];
               i_in      = '0;
               acc_start = 1'b1;
            end
         end
         ST_TAPS: begin
            if (issue) i_in = i_ff + CW'(1);
         end
         ST_EMIT: begin
            // the held result goes out only once we know another follows it
            if (!pend_v_ff || !rsp_full) begin
               rsp_push             = pend_v_ff;
               rsp_data.last_of_run = 1'b0;
               pend_in              = res_new;
               pend_v_in            = 1'b1;
               col_in               = col_ff + OCW'(1);
               n_in                 = n_ff + NW'(1);
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff || !rsp_full) begin
               rsp_push             = pend_v_ff;
               rsp_data.last_of_run = 1'b1;
               pend_v_in            = 1'b0;
               if (last_ff) begin
                  ptr_in = '0;
                  col_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // tap pipeline: read, multiply, accumulate
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mul[c]     = $signed({1'b0, px_rd[23 - 8*c -: 8]}) * w_rd;
         prod_in[c] = nz1_ff ? mul[c][31:0] : 32'd0;
         if (acc_start) begin
            acc_in[c] = BIAS;
         end else if (v2_ff) begin
            acc_in[c] = acc_ff[c] + prod_ff[c];
         end else begin
            acc_in[c] = acc_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ptr_ff    <= '0;
         col_ff    <= '0;
         n_ff      <= '0;
         last_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         col_ff    <= col_in;
         n_ff      <= n_in;
         last_ff   <= last_in;
         pend_v_ff <= pend_v_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
      i_ff     <= i_in;
      nz1_ff   <= src_ok;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      pend_ff  <= pend_in;
   end

   brr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rq_rdata),
      .empty (empty)
   );

   assign rsp = rsp_type'(rq_rdata);

endmodule

/* rtl/core/bicubic_row_resampler_core.sv */
// top level of the bicubic row resampler: register port, front end and back end
// depends on brr_pkg, brr_front and brr_back
//
// usage: write in_width (byte address 0) and out_width (byte address 4) through the
// register port while the block is idle. push span loads (mode 0) and weight loads
// (mode 1) before the pixels of a row, then push pixels (mode 2) in column order.
// input is a queue: an item is taken when push is high and full is low. results are
// a queue: the oldest result stands on the rsp_ ports while empty is low and is
// taken when pop is high.
// a load is written in the idle state; a pixel is stored, then each column it
// completes has its span read and checked, its taps walked (one tap a cycle, set
// by the single read port of the row store and weight table), the tap pipeline
// drained and its result emitted. a two-entry command queue lets the front end
// take items while the back end works. the result of a column is held until the
// back end knows whether another column follows, so it enters the result queue
// after the walk of the next column when that one is ready, else on the flush. a
// stalled receiver fills the two-entry result queue, the back end then waits and
// the command queue fills until full rises. reset clears the queues, the pixel
// pointer and the column counter; the tables and row store keep their contents.
module bicubic_row_resampler_core import brr_pkg::*; #(
   parameter int MAX_IN_WIDTH  = 2048,
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_TAPS      = 16,
   parameter int FRACTION_BITS = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_out_index,
   input  logic [3:0]         req_tap,
   input  logic [10:0]        req_first_pixel,
   input  logic [4:0]         req_tap_count,
   input  logic signed [24:0] req_weight,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   output logic               empty,
   input  logic               pop,
   output logic [9:0]         rsp_column,
   output logic [7:0]         rsp_red_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_blue_out,
   output logic               rsp_last_of_run,
   output logic               rsp_row_done,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [11:0] in_width_ff, in_width_in;
   logic [10:0] out_width_ff, out_width_in;
   logic        csr_write;
   cfg_type     cfg;
   cmd_type     cmd;
   logic        cmd_empty, cmd_pop;
   rsp_type     rsp;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      in_width_in  = in_width_ff;
      out_width_in = out_width_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_IN_WIDTH:  in_width_in  = pwdata[11:0];
            REG_OUT_WIDTH: out_width_in = pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_IN_WIDTH:  prdata = {20'd0, in_width_ff};
         REG_OUT_WIDTH: prdata = {21'd0, out_width_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= 12'd1;
         out_width_ff <= 11'd1;
      end else begin
         in_width_ff  <= in_width_in;
         out_width_ff <= out_width_in;
      end
   end

   assign cfg.in_width  = in_width_ff;
   assign cfg.out_width = out_width_ff;

   brr_front #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_TAPS      (MAX_TAPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_out_index   (req_out_index),
      .req_tap         (req_tap),
      .req_first_pixel (req_first_pixel),
      .req_tap_count   (req_tap_count),
      .req_weight      (req_weight),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd),
      .cmd_empty       (cmd_empty)
   );

   brr_back #(
      .MAX_IN_WIDTH  (MAX_IN_WIDTH),
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_TAPS      (MAX_TAPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .rsp       (rsp),
      .empty     (empty)
   );

   assign rsp_column      = rsp.column;
   assign rsp_red_out     = rsp.red;
   assign rsp_green_out   = rsp.green;
   assign rsp_blue_out    = rsp.blue;
   assign rsp_last_of_run = rsp.last_of_run;
   assign rsp_row_done    = rsp.row_done;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   a_csr_in_width: assert property (@(posedge clock) disable iff (reset)
      (csr_write && paddr[2] == REG_IN_WIDTH) |=> (in_width_ff == $past(pwdata[11:0])))
      else $error("in_width write lost");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_row_done) |-> rsp_last_of_run)
      else $error("last column of row not marked as end of run");

endmodule
